FILE: hdl/lru_key_value_cache_defines.svh
// Assertion macros shared by the checker of lru_key_value_cache.
// No dependencies; taken in by `include where assertions are written.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LKV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked after the antecedent
`define LKV_ASSERT_TWO(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: hdl/lkv_pkg.sv
// Package for the LRU key/value cache: widths, command codes, reset values
// and the control struct that the top level hands to every cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkv_pkg;

  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int DEPTH_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Per-cycle control broadcast along the chain
  typedef struct packed {
    logic cmp_en;   // latch the key compare for a new transfer
    logic upd_en;   // update phase that reorders the chain
    logic hit;      // update is a hit: load up to the matching cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/lkv_cell.sv
// One cell of the recency chain: holds the entry of one recency rank.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkv_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  wire                          clk,
  input  wire lkv_pkg::cell_ctrl_t     ctrl,
  input  wire [CW-1:0]                 count,
  input  wire [CW-1:0]                 lim,
  input  wire [lkv_pkg::DATA_W-1:0]    cmp_key,
  input  wire [lkv_pkg::DATA_W-1:0]    prev_key,
  input  wire [lkv_pkg::DATA_W-1:0]    prev_value,
  input  wire                          seen_in,
  output logic                         seen_out,
  output logic [lkv_pkg::DATA_W-1:0]   key_o,
  output logic [lkv_pkg::DATA_W-1:0]   value_o,
  output logic                         match_o,
  output logic                         last_o
);

  logic [lkv_pkg::DATA_W-1:0] key_r;
  logic [lkv_pkg::DATA_W-1:0] value_r;
  logic                       match_r;
  logic                       valid;
  logic                       load;

  // Cells below the fill count hold live entries
  assign valid = CW'(IDX) < count;

  // Hit: load every cell up to the match; miss: up to the limit
  assign load = ctrl.upd_en && (ctrl.hit ? !seen_in : (CW'(IDX) <= lim));

  // Compare at transfer, shift from the neighbour in the update phase
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= valid && (key_r == cmp_key);
    end
    if (load) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

  assign seen_out = seen_in | match_r;
  assign match_o  = match_r;
  assign key_o    = key_r;
  assign value_o  = value_r;
  // Least recent live entry
  assign last_o   = valid && (CW'(IDX + 1) == count);

endmodule

`default_nettype wire

FILE: hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: control, fill count and result regs
// around a chain of lkv_cell instances. Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   A request (in_cmd get/put, in_key, in_value) transfers on a rising edge
//   with start high and busy low. busy is then high for one cycle while the
//   chain reorders; the result (out_hit, out_read_value, out_evicted,
//   out_evicted_key) is shown with out_valid for exactly one cycle, the cycle
//   after the update. busy drops together with out_valid rising, so a new
//   request may transfer while a result is on show. A request cannot
//   transfer in the update cycle, in which the cells up to the match (hit)
//   or up to the limit (put miss) load from their neighbour; a get miss
//   loads no cell.
//   Entries sit in recency order: cell 0 is most recent; a hit or an insert
//   moves entries one cell along the chain and puts the request in cell 0.
//   cfg_we/cfg_wdata write the capacity register (0 acts as 1, above DEPTH
//   acts as DEPTH); write only while idle.
//   Reset (rst_n low, synchronous) empties the cache and sets capacity 16.
//   The receiver cannot stall; out_valid is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int DEPTH = lkv_pkg::DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_cmd,
  input  wire signed [lkv_pkg::DATA_W-1:0]    in_key,
  input  wire signed [lkv_pkg::DATA_W-1:0]    in_value,
  input  wire                                 cfg_we,
  input  wire [lkv_pkg::CAP_W-1:0]            cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0]   out_read_value,
  output logic                                out_evicted,
  output logic signed [lkv_pkg::DATA_W-1:0]   out_evicted_key
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;
  localparam int DW   = lkv_pkg::DATA_W;

  // Control and request registers
  logic                      busy_r, busy_nxt;
  logic                      cmd_r;
  logic [DW-1:0]             key_r;
  logic [DW-1:0]             value_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  // Result registers
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [DW-1:0]             out_rd_r;
  logic                      out_ev_r;
  logic [DW-1:0]             out_evk_r;

  // Chain wiring
  logic [DEPTH:0]            seen;
  logic [DW-1:0]             cell_key   [DEPTH];
  logic [DW-1:0]             cell_value [DEPTH];
  logic [DEPTH-1:0]          cell_match;
  logic [DEPTH-1:0]          cell_last;
  logic [DW-1:0]             head_value;

  logic                      accept;
  logic                      hit_any;
  logic                      evict;
  logic [DW-1:0]             rd_value;
  logic [DW-1:0]             ev_key;
  logic [CW-1:0]             lim;
  logic [CMPW-1:0]           cap_ext, cap_eff, cnt_ext;
  lkv_pkg::cell_ctrl_t       ctrl;

  assign accept  = start && !busy_r;
  assign hit_any = seen[DEPTH];

  // Effective capacity, clamped to 1..DEPTH
  always_comb begin
    cap_ext = CMPW'(cap_r);
    cnt_ext = CMPW'(count_r);
    priority if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(DEPTH)) begin
      cap_eff = CMPW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign evict = !hit_any && (cmd_r == lkv_pkg::CMD_PUT) && (cnt_ext >= cap_eff);
  assign lim   = evict ? (count_r - CW'(1)) : count_r;

  // Gather matched value and least recent key from the chain
  always_comb begin
    rd_value = '0;
    ev_key   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | (cell_value[i] & {DW{cell_match[i]}});
      ev_key   = ev_key   | (cell_key[i]   & {DW{cell_last[i]}});
    end
  end

  // Head of the chain takes the request; a get hit keeps the stored value
  assign head_value = (cmd_r == lkv_pkg::CMD_PUT) ? value_r : rd_value;

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.upd_en = busy_r && (hit_any || (cmd_r == lkv_pkg::CMD_PUT));
    ctrl.hit    = hit_any;
  end

  assign seen[0] = 1'b0;

  // Recency chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lkv_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .lim        (lim),
      .cmp_key    (in_key),
      .prev_key   ((g == 0) ? key_r : cell_key[(g == 0) ? 0 : g - 1]),
      .prev_value ((g == 0) ? head_value : cell_value[(g == 0) ? 0 : g - 1]),
      .seen_in    (seen[g]),
      .seen_out   (seen[g + 1]),
      .key_o      (cell_key[g]),
      .value_o    (cell_value[g]),
      .match_o    (cell_match[g]),
      .last_o     (cell_last[g])
    );
  end

  // Next state of control
  always_comb begin
    busy_nxt  = accept;
    count_nxt = count_r;
    if (busy_r && !hit_any && (cmd_r == lkv_pkg::CMD_PUT) && !evict) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      cap_r       <= lkv_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= busy_r;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (busy_r) begin
      out_hit_r <= hit_any;
      out_rd_r  <= (hit_any && (cmd_r == lkv_pkg::CMD_GET)) ? rd_value : '0;
      out_ev_r  <= evict;
      out_evk_r <= evict ? ev_key : '0;
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

`default_nettype wire

FILE: hdl/lkv_checker.sv
// Port-level checker for lru_key_value_cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lru_key_value_cache_defines.svh"

module lkv_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire                          out_valid,
  input wire                          out_hit,
  input wire [lkv_pkg::DATA_W-1:0]    out_read_value,
  input wire                          out_evicted,
  input wire [lkv_pkg::DATA_W-1:0]    out_evicted_key
);

  logic xfer;
  logic res_miss;
  logic res_no_ev;

  assign xfer      = start && !busy;
  assign res_miss  = out_valid && !out_hit;
  assign res_no_ev = out_valid && !out_evicted;

  // A transfer occupies the block for the update cycle
  `LKV_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, xfer, busy, "no busy after transfer")

  // Every transfer yields a result strobe after its update cycle
  `LKV_ASSERT_TWO(a_result_latency, clk, rst_n, xfer, out_valid, "result strobe missing")

  // A result only follows an update cycle
  `LKV_ASSERT_SAME(a_result_source, clk, rst_n, out_valid, $past(busy) && !busy, "stray strobe")

  // A miss reads zero
  `LKV_ASSERT_SAME(a_miss_fields, clk, rst_n, res_miss, out_read_value == '0, "miss with data")

  // No evicted key without an eviction
  `LKV_ASSERT_SAME(a_evict_fields, clk, rst_n, res_no_ev, out_evicted_key == '0, "stray evict key")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_read_value  (out_read_value),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);

`default_nettype wire

FILE: sim/tb_lru_key_value_cache.sv
// Self-checking testbench for lru_key_value_cache: directed table, then random
// get/put traffic over several capacity settings, checked against an LRU shadow.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

  localparam int SLOTS       = 16;
  localparam int IDLE_LIMIT  = 500;
  localparam int PHASE_ITEMS = 155;
  localparam int NUM_PHASES  = 10;
  localparam int DW          = lkv_pkg::DATA_W;
  localparam int CAPW        = lkv_pkg::CAP_W;

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] read_value;
    logic          evicted;
    logic [DW-1:0] evicted_key;
  } access_resp_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One directed step: a request, or a capacity write between requests
  typedef struct packed {
    row_kind_t       kind;
    logic            cmd;
    logic [DW-1:0]   key;
    logic [DW-1:0]   value;
    logic [CAPW-1:0] cap;
    logic            fixed;
    access_resp_t    resp;
  } dir_row_t;

  localparam logic GET = lkv_pkg::CMD_GET;
  localparam logic PUT = lkv_pkg::CMD_PUT;

  localparam access_resp_t MISS = '{1'b0, 32'h0, 1'b0, 32'h0};
  localparam access_resp_t ANY  = '{1'b0, 32'h0, 1'b0, 32'h0};

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty after reset
    '{ROW_ITEM, GET, 32'h0000_0000, 32'hDEAD_BEEF, 5'd0, 1'b1, MISS},
    '{ROW_ITEM, PUT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1, MISS},
    '{ROW_ITEM, PUT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b1, MISS},
    '{ROW_ITEM, PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, MISS},
    // hits on extreme keys; a stored -1 must come back as data, not a miss
    '{ROW_ITEM, GET, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
    '{ROW_ITEM, GET, 32'hFFFF_FFFF, 32'h1234_5678, 5'd0, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
    // put hit reads back zero
    '{ROW_ITEM, PUT, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_ITEM, GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_ITEM, GET, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b1, MISS},
    // capacity zero acts as one, and now sits below the fill count
    '{ROW_CFG,  GET, 32'h0,         32'h0,         5'd0,  1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0001, 32'h0000_000B, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0002, 32'h0000_0016, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, GET, 32'h0000_0001, 32'h0000_0000, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, ANY},
    '{ROW_CFG,  GET, 32'h0,         32'h0,         5'd1,  1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0003, 32'h5555_5555, 5'd0, 1'b0, ANY},
    // above DEPTH acts as DEPTH
    '{ROW_CFG,  GET, 32'h0,         32'h0,         5'd31, 1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0004, 32'hAAAA_AAAA, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0005, 32'h0000_0001, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, GET, 32'h0000_0002, 32'h0000_0000, 5'd0, 1'b0, ANY},
    '{ROW_CFG,  GET, 32'h0,         32'h0,         5'd17, 1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, ANY},
    '{ROW_CFG,  GET, 32'h0,         32'h0,         5'd16, 1'b0, ANY},
    '{ROW_ITEM, PUT, 32'h0000_0000, 32'hAAAA_AAAA, 5'd0, 1'b0, ANY},
    '{ROW_ITEM, GET, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b0, ANY}
  };

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   in_cmd    = lkv_pkg::CMD_GET;
  logic        [DW-1:0]   in_key    = '0;
  logic        [DW-1:0]   in_value  = '0;
  logic                   cfg_we    = 1'b0;
  logic        [CAPW-1:0] cfg_wdata = '0;
  logic                   busy;
  logic                   out_valid;
  logic                   out_hit;
  logic signed [DW-1:0]   out_read_value;
  logic                   out_evicted;
  logic signed [DW-1:0]   out_evicted_key;

  // Shadow of the store, slot based; ranks 0 = most recent
  logic            shadow_valid [SLOTS];
  logic [DW-1:0]   shadow_key   [SLOTS];
  logic [DW-1:0]   shadow_val   [SLOTS];
  logic [3:0]      shadow_rank  [SLOTS];
  logic [CAPW-1:0] shadow_count;
  logic [CAPW-1:0] shadow_cap;

  access_resp_t resp_due [$];
  int           mismatch_count = 0;
  int           idle_cycles    = 0;

  lru_key_value_cache i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  always #1 clk = ~clk;

  function automatic int usable_capacity(logic [CAPW-1:0] cap);
    int c;
    c = cap;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // Move one slot to the front; anything more recent ages by one
  function automatic void make_most_recent(int s);
    logic [3:0] r;
    r = shadow_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[s] = 4'd0;
  endfunction

  // Apply one get/put to the shadow store and return what the block must show
  function automatic access_resp_t lru_access(logic cmd, logic [DW-1:0] k,
                                              logic [DW-1:0] v);
    access_resp_t r;
    int           slot;
    bit           found;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (!r.hit && shadow_valid[i] && shadow_key[i] == k) begin
        r.hit = 1'b1;
        slot  = i;
      end
    if (r.hit) begin
      if (cmd == lkv_pkg::CMD_GET) r.read_value = shadow_val[slot];
      else shadow_val[slot] = v;
      make_most_recent(slot);
    end else if (cmd == lkv_pkg::CMD_PUT) begin
      if (shadow_count >= usable_capacity(shadow_cap)) begin
        // full: the oldest entry gives up its slot
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i] && (!found || shadow_rank[i] > shadow_rank[slot])) begin
            slot  = i;
            found = 1'b1;
          end
        r.evicted     = 1'b1;
        r.evicted_key = shadow_key[slot];
        make_most_recent(slot);
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!shadow_valid[i]) slot = i;
        for (int i = 0; i < SLOTS; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot]  = 4'd0;
        shadow_count++;
      end
      shadow_key[slot] = k;
      shadow_val[slot] = v;
    end
    return r;
  endfunction

  // Present a request and hold it until the transfer; start is left high
  task automatic drive_access(logic cmd, logic [DW-1:0] k, logic [DW-1:0] v,
                              bit fixed, access_resp_t fixed_resp);
    access_resp_t r;
    in_cmd   <= cmd;
    in_key   <= k;
    in_value <= v;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = lru_access(cmd, k, v);
    resp_due.push_back(fixed ? fixed_resp : r);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Capacity is only written once every pending result has come out
  task automatic write_capacity(logic [CAPW-1:0] v);
    start <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap  = v;
  endtask

  function automatic logic [DW-1:0] corner_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (resp_due.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_count++;
      end else begin
        access_resp_t want;
        want = resp_due.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0h actual %0h", want.hit, out_hit);
          mismatch_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %h actual %h", want.read_value, out_read_value);
          mismatch_count++;
        end
        if (out_evicted !== want.evicted) begin
          $error("evicted: expected %0h actual %0h", want.evicted, out_evicted);
          mismatch_count++;
        end
        if (out_evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h actual %h", want.evicted_key, out_evicted_key);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [CAPW-1:0] phase_caps [NUM_PHASES];
    logic [DW-1:0]   key_pool [$];
    logic [DW-1:0]   k;
    logic [DW-1:0]   v;
    int              pool_len;
    bit              no_idle;

    phase_caps = '{5'd16, 5'd1, 5'd2, 5'd4, 5'd8, 5'd15, 5'd31, 5'd0, 5'd17, 5'd3};

    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_val[i]   = '0;
      shadow_rank[i]  = '0;
    end
    shadow_count = '0;
    shadow_cap   = lkv_pkg::CAP_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_capacity(DIR_TABLE[i].cap);
      end else begin
        drive_access(DIR_TABLE[i].cmd, DIR_TABLE[i].key, DIR_TABLE[i].value,
                     DIR_TABLE[i].fixed, DIR_TABLE[i].resp);
        idle_gap(pick_gap(1'b0));
      end
    end

    // random phases: each with its own capacity and a key pool a bit larger
    // than the capacity, so hits, misses and evictions all happen
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) phase_caps[p] = CAPW'($urandom_range(0, 31));
      write_capacity(phase_caps[p]);
      pool_len = usable_capacity(phase_caps[p]) + int'($urandom_range(1, 8));
      key_pool.delete();
      for (int i = 0; i < pool_len; i++)
        key_pool.push_back(($urandom_range(0, 7) == 0) ? corner_word() : DW'($urandom));
      no_idle = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // a tenth of the keys come from outside the pool
        if ($urandom_range(0, 9) == 0) k = DW'($urandom);
        else k = key_pool[$urandom_range(0, pool_len - 1)];
        v = ($urandom_range(0, 9) == 0) ? corner_word() : DW'($urandom);
        drive_access(1'($urandom_range(0, 1)), k, v, 1'b0, ANY);
        idle_gap(pick_gap(no_idle));
      end
    end

    // drain, then a short tail for stray strobes
    start <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (resp_due.size() != 0) begin
      $error("%0d expected results never arrived", resp_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
